[design/thread_lock_condvar_scheduler_top_macros.svh]
// Assertion macros for the thread, lock and condition scheduler.
// Bodies refer to clk and rst_n of the including module.
`ifndef THREAD_LOCK_CONDVAR_SCHEDULER_TOP_MACROS_SVH
`define THREAD_LOCK_CONDVAR_SCHEDULER_TOP_MACROS_SVH

`define THLK_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define THLK_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/thlk_pkg.sv]
// Package for the thread, lock and condition scheduler.
// Op, status and thread state codes, sequencer states, slot defaults.
`default_nettype none
package thlk_pkg;
    localparam int THREAD_SLOTS_DEF = 16;
    localparam int LOCK_SLOTS_DEF   = 16;
    localparam int COND_SLOTS_DEF   = 16;

    localparam logic [3:0] OP_INIT      = 4'd0;
    localparam logic [3:0] OP_CREATE    = 4'd1;
    localparam logic [3:0] OP_YIELD     = 4'd2;
    localparam logic [3:0] OP_LOCK      = 4'd3;
    localparam logic [3:0] OP_UNLOCK    = 4'd4;
    localparam logic [3:0] OP_WAIT      = 4'd5;
    localparam logic [3:0] OP_SIGNAL    = 4'd6;
    localparam logic [3:0] OP_BROADCAST = 4'd7;
    localparam logic [3:0] OP_FINISH    = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INIT_ERR = 3'd1;
    localparam logic [2:0] ST_NOT_OWN  = 3'd2;
    localparam logic [2:0] ST_NO_FREE  = 3'd3;
    localparam logic [2:0] ST_HALTED   = 3'd4;

    localparam logic [2:0] TS_FREE     = 3'd0;
    localparam logic [2:0] TS_RUN      = 3'd1;
    localparam logic [2:0] TS_READY    = 3'd2;
    localparam logic [2:0] TS_LOCKWAIT = 3'd3;
    localparam logic [2:0] TS_CONDWAIT = 3'd4;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_SCAN  = 12'b000000000100,
        S_DISP  = 12'b000000001000,
        S_DNEXT = 12'b000000010000,
        S_DCHK  = 12'b000000100000,
        S_REL0  = 12'b000001000000,
        S_REL1  = 12'b000010000000,
        S_COND  = 12'b000100000000,
        S_CPUT  = 12'b001000000000,
        S_CTAKE = 12'b010000000000,
        S_CNEXT = 12'b100000000000
    } state_t;
endpackage
`default_nettype wire

[design/thlk_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module thlk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/thread_lock_condvar_scheduler_top.sv]
// Top level of the thread, lock and condition scheduler.
// Uses thlk_pkg, thlk_ram and the assertion macro header.
//
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done and cannot be stalled. Errors, init and
// halted requests finish straight from idle. Create scans one slot a cycle
// for a free thread; a switch takes ready threads in turn until one can run,
// and halts if none is ready; wait queues the thread on the condition, then
// releases its lock; broadcast wakes the waiting threads one by one. After
// reset busy stays high while the condition queue memory is cleared.
`default_nettype none
`include "thread_lock_condvar_scheduler_top_macros.svh"
module thread_lock_condvar_scheduler_top #(
    parameter int THREAD_SLOTS = thlk_pkg::THREAD_SLOTS_DEF,
    parameter int LOCK_SLOTS   = thlk_pkg::LOCK_SLOTS_DEF,
    parameter int COND_SLOTS   = thlk_pkg::COND_SLOTS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [3:0] op,
    input  wire logic [3:0] lock_id,
    input  wire logic [3:0] cond_id,
    output logic            done,
    output logic [2:0]      status,
    output logic [3:0]      running_thread,
    output logic [3:0]      new_thread,
    output logic            halted
);
    localparam int TW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int LW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int CD = LOCK_SLOTS * COND_SLOTS;
    localparam int CW = (CD > 1) ? $clog2(CD) : 1;
    localparam int QW = 2 * TW + 1;

    thlk_pkg::state_t state_reg, state_next;
    logic          init_reg, init_next;
    logic          halt_reg, halt_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [3:0]    op_reg, op_next;
    logic [LW-1:0] l_reg, l_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [TW-1:0] t_reg, t_next;
    logic          done_reg, done_next;
    logic [2:0]    st_reg, st_next;
    logic [TW-1:0] nt_reg, nt_next;
    logic [2:0]    ts_reg [THREAD_SLOTS];
    logic [2:0]    ts_next [THREAD_SLOTS];
    logic          rv_reg [THREAD_SLOTS];
    logic          rv_next [THREAD_SLOTS];
    logic [LW-1:0] rp_reg [THREAD_SLOTS];
    logic [LW-1:0] rp_next [THREAD_SLOTS];
    logic [TW-1:0] rqh_reg, rqh_next, rqt_reg, rqt_next;
    logic          rqb_reg, rqb_next;
    logic          ov_reg [LOCK_SLOTS];
    logic          ov_next [LOCK_SLOTS];
    logic [TW-1:0] own_reg [LOCK_SLOTS];
    logic [TW-1:0] own_next [LOCK_SLOTS];
    logic [TW-1:0] lqh_reg [LOCK_SLOTS];
    logic [TW-1:0] lqh_next [LOCK_SLOTS];
    logic [TW-1:0] lqt_reg [LOCK_SLOTS];
    logic [TW-1:0] lqt_next [LOCK_SLOTS];
    logic          lqb_reg [LOCK_SLOTS];
    logic          lqb_next [LOCK_SLOTS];
    logic [TW-1:0] cqh_reg, cqh_next, cqt_reg, cqt_next;
    logic          cqb_reg, cqb_next;

    logic          nx_we;
    logic [TW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic          cq_we;
    logic [CW-1:0] cq_waddr;
    logic [QW-1:0] cq_wdata, cq_rdata;

    logic          mr_en, lp_en;
    logic [TW-1:0] mr_thr, lp_thr;
    logic [LW-1:0] lp_l, l_in, lr;
    logic [8:0]    lk_w, cd_w;
    logic [16:0]   c_full;
    logic [CW-1:0] c_in;
    logic          lock_ok, pair_ok, owns_in;
    logic [8:0]    cur_w, nt_w;

    thlk_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    thlk_ram #(.WIDTH(QW), .DEPTH(CD)) u_cond_ram (
        .clk   (clk),
        .we    (cq_we),
        .waddr (cq_waddr),
        .wdata (cq_wdata),
        .raddr (c_in),
        .rdata (cq_rdata)
    );

    always_comb
    begin
        lk_w    = {5'd0, lock_id};
        cd_w    = {5'd0, cond_id};
        lock_ok = lk_w < 9'(LOCK_SLOTS);
        pair_ok = lock_ok && (cd_w < 9'(COND_SLOTS));
        l_in    = lk_w[LW-1:0];
        c_full  = 17'(lk_w) * 17'(COND_SLOTS) + 17'(cd_w);
        c_in    = c_full[CW-1:0];
        owns_in = ov_reg[l_in] && (own_reg[l_in] == cur_reg);
        lr      = rp_reg[t_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        halt_next  = halt_reg;
        cur_next   = cur_reg;
        op_next    = op_reg;
        l_next     = l_reg;
        c_next     = c_reg;
        clr_next   = clr_reg;
        t_next     = t_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        nt_next    = nt_reg;
        ts_next    = ts_reg;
        rv_next    = rv_reg;
        rp_next    = rp_reg;
        rqh_next   = rqh_reg;
        rqt_next   = rqt_reg;
        rqb_next   = rqb_reg;
        ov_next    = ov_reg;
        own_next   = own_reg;
        lqh_next   = lqh_reg;
        lqt_next   = lqt_reg;
        lqb_next   = lqb_reg;
        cqh_next   = cqh_reg;
        cqt_next   = cqt_reg;
        cqb_next   = cqb_reg;
        nx_we      = 1'b0;
        nx_waddr   = rqt_reg;
        nx_wdata   = cur_reg;
        nx_raddr   = rqh_reg;
        cq_we      = 1'b0;
        cq_waddr   = c_reg;
        mr_en      = 1'b0;
        mr_thr     = t_reg;
        lp_en      = 1'b0;
        lp_thr     = cur_reg;
        lp_l       = l_in;

        unique case (state_reg)
            thlk_pkg::S_CLEAR:
            begin
                cq_we    = 1'b1;
                cq_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CD - 1))
                begin
                    state_next = thlk_pkg::S_IDLE;
                end
            end
            thlk_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next = op;
                    nt_next = '0;
                    st_next = thlk_pkg::ST_OK;
                    if (halt_reg)
                    begin
                        done_next = 1'b1;
                        st_next   = thlk_pkg::ST_HALTED;
                    end
                    else if (op == thlk_pkg::OP_INIT)
                    begin
                        done_next = 1'b1;
                        if (init_reg)
                        begin
                            st_next = thlk_pkg::ST_INIT_ERR;
                        end
                        else
                        begin
                            init_next  = 1'b1;
                            cur_next   = '0;
                            ts_next[0] = thlk_pkg::TS_RUN;
                        end
                    end
                    else if (op > thlk_pkg::OP_FINISH)
                    begin
                        done_next = 1'b1;
                    end
                    else if (!init_reg)
                    begin
                        done_next = 1'b1;
                        st_next   = thlk_pkg::ST_INIT_ERR;
                    end
                    else
                    begin
                        case (op) inside
                            thlk_pkg::OP_CREATE:
                            begin
                                t_next     = '0;
                                state_next = thlk_pkg::S_SCAN;
                            end
                            thlk_pkg::OP_YIELD:
                            begin
                                mr_en      = 1'b1;
                                mr_thr     = cur_reg;
                                state_next = thlk_pkg::S_DISP;
                            end
                            thlk_pkg::OP_LOCK:
                            begin
                                if (!lock_ok || owns_in)
                                begin
                                    done_next = 1'b1;
                                    st_next   = thlk_pkg::ST_NOT_OWN;
                                end
                                else if (!ov_reg[l_in])
                                begin
                                    done_next      = 1'b1;
                                    ov_next[l_in]  = 1'b1;
                                    own_next[l_in] = cur_reg;
                                end
                                else
                                begin
                                    ts_next[cur_reg] = thlk_pkg::TS_LOCKWAIT;
                                    lp_en            = 1'b1;
                                    state_next       = thlk_pkg::S_DISP;
                                end
                            end
                            thlk_pkg::OP_UNLOCK:
                            begin
                                if (!lock_ok || !owns_in)
                                begin
                                    done_next = 1'b1;
                                    st_next   = thlk_pkg::ST_NOT_OWN;
                                end
                                else
                                begin
                                    l_next     = l_in;
                                    state_next = thlk_pkg::S_REL0;
                                end
                            end
                            thlk_pkg::OP_WAIT:
                            begin
                                if (!pair_ok || !owns_in)
                                begin
                                    done_next = 1'b1;
                                    st_next   = thlk_pkg::ST_NOT_OWN;
                                end
                                else
                                begin
                                    ts_next[cur_reg] = thlk_pkg::TS_CONDWAIT;
                                    rv_next[cur_reg] = 1'b1;
                                    rp_next[cur_reg] = l_in;
                                    l_next           = l_in;
                                    c_next           = c_in;
                                    state_next       = thlk_pkg::S_COND;
                                end
                            end
                            thlk_pkg::OP_SIGNAL, thlk_pkg::OP_BROADCAST:
                            begin
                                if (pair_ok)
                                begin
                                    c_next     = c_in;
                                    state_next = thlk_pkg::S_COND;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                ts_next[cur_reg] = thlk_pkg::TS_FREE;
                                rv_next[cur_reg] = 1'b0;
                                state_next       = thlk_pkg::S_DISP;
                            end
                        endcase
                    end
                end
            end
            thlk_pkg::S_SCAN:
            begin
                if (ts_reg[t_reg] == thlk_pkg::TS_FREE)
                begin
                    rv_next[t_reg] = 1'b0;
                    mr_en          = 1'b1;
                    nt_next        = t_reg;
                    done_next      = 1'b1;
                    state_next     = thlk_pkg::S_IDLE;
                end
                else if (t_reg == TW'(THREAD_SLOTS - 1))
                begin
                    st_next    = thlk_pkg::ST_NO_FREE;
                    done_next  = 1'b1;
                    state_next = thlk_pkg::S_IDLE;
                end
                else
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            thlk_pkg::S_DISP:
            begin
                if (!rqb_reg)
                begin
                    halt_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = thlk_pkg::S_IDLE;
                end
                else
                begin
                    t_next = rqh_reg;
                    if (rqh_reg == rqt_reg)
                    begin
                        rqb_next   = 1'b0;
                        state_next = thlk_pkg::S_DCHK;
                    end
                    else
                    begin
                        state_next = thlk_pkg::S_DNEXT;
                    end
                end
            end
            thlk_pkg::S_DNEXT:
            begin
                rqh_next   = nx_rdata;
                state_next = thlk_pkg::S_DCHK;
            end
            thlk_pkg::S_DCHK:
            begin
                state_next = thlk_pkg::S_IDLE;
                done_next  = 1'b1;
                cur_next   = t_reg;
                ts_next[t_reg] = thlk_pkg::TS_RUN;
                if (rv_reg[t_reg])
                begin
                    rv_next[t_reg] = 1'b0;
                    if (!ov_reg[lr])
                    begin
                        ov_next[lr]  = 1'b1;
                        own_next[lr] = t_reg;
                    end
                    else if (own_reg[lr] != t_reg)
                    begin
                        ts_next[t_reg] = thlk_pkg::TS_LOCKWAIT;
                        cur_next       = cur_reg;
                        done_next      = 1'b0;
                        lp_en          = 1'b1;
                        lp_l           = lr;
                        lp_thr         = t_reg;
                        state_next     = thlk_pkg::S_DISP;
                    end
                end
            end
            thlk_pkg::S_REL0:
            begin
                ov_next[l_reg] = 1'b0;
                if (lqb_reg[l_reg])
                begin
                    t_next     = lqh_reg[l_reg];
                    nx_raddr   = lqh_reg[l_reg];
                    state_next = thlk_pkg::S_REL1;
                end
                else if (op_reg == thlk_pkg::OP_WAIT)
                begin
                    state_next = thlk_pkg::S_DISP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = thlk_pkg::S_IDLE;
                end
            end
            thlk_pkg::S_REL1:
            begin
                if (lqh_reg[l_reg] == lqt_reg[l_reg])
                begin
                    lqb_next[l_reg] = 1'b0;
                end
                else
                begin
                    lqh_next[l_reg] = nx_rdata;
                end
                ov_next[l_reg]  = 1'b1;
                own_next[l_reg] = t_reg;
                mr_en           = 1'b1;
                if (op_reg == thlk_pkg::OP_WAIT)
                begin
                    state_next = thlk_pkg::S_DISP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = thlk_pkg::S_IDLE;
                end
            end
            thlk_pkg::S_COND:
            begin
                cqb_next = cq_rdata[QW-1];
                cqh_next = cq_rdata[2*TW-1:TW];
                cqt_next = cq_rdata[TW-1:0];
                if (op_reg == thlk_pkg::OP_WAIT)
                begin
                    state_next = thlk_pkg::S_CPUT;
                end
                else
                begin
                    state_next = thlk_pkg::S_CTAKE;
                end
            end
            thlk_pkg::S_CPUT:
            begin
                if (cqb_reg)
                begin
                    nx_we    = 1'b1;
                    nx_waddr = cqt_reg;
                    nx_wdata = cur_reg;
                end
                else
                begin
                    cqh_next = cur_reg;
                    cqb_next = 1'b1;
                end
                cqt_next   = cur_reg;
                cq_we      = 1'b1;
                state_next = thlk_pkg::S_REL0;
            end
            thlk_pkg::S_CTAKE:
            begin
                if (!cqb_reg)
                begin
                    done_next  = 1'b1;
                    state_next = thlk_pkg::S_IDLE;
                end
                else
                begin
                    t_next   = cqh_reg;
                    nx_raddr = cqh_reg;
                    if (cqh_reg == cqt_reg)
                    begin
                        cqb_next = 1'b0;
                        cq_we    = 1'b1;
                        mr_en    = 1'b1;
                        mr_thr   = cqh_reg;
                        if (op_reg == thlk_pkg::OP_SIGNAL)
                        begin
                            done_next  = 1'b1;
                            state_next = thlk_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = thlk_pkg::S_CNEXT;
                    end
                end
            end
            thlk_pkg::S_CNEXT:
            begin
                cqh_next = nx_rdata;
                cq_we    = 1'b1;
                mr_en    = 1'b1;
                if (op_reg == thlk_pkg::OP_SIGNAL)
                begin
                    done_next  = 1'b1;
                    state_next = thlk_pkg::S_IDLE;
                end
                else
                begin
                    state_next = thlk_pkg::S_CTAKE;
                end
            end
            default:
            begin
                state_next = thlk_pkg::S_IDLE;
            end
        endcase

        // ready queue append
        if (mr_en)
        begin
            ts_next[mr_thr] = thlk_pkg::TS_READY;
            if (rqb_reg)
            begin
                nx_we    = 1'b1;
                nx_waddr = rqt_reg;
                nx_wdata = mr_thr;
            end
            else
            begin
                rqh_next = mr_thr;
                rqb_next = 1'b1;
            end
            rqt_next = mr_thr;
        end

        // lock queue append
        if (lp_en)
        begin
            if (lqb_reg[lp_l])
            begin
                nx_we    = 1'b1;
                nx_waddr = lqt_reg[lp_l];
                nx_wdata = lp_thr;
            end
            else
            begin
                lqh_next[lp_l] = lp_thr;
                lqb_next[lp_l] = 1'b1;
            end
            lqt_next[lp_l] = lp_thr;
        end

        cq_wdata = state_reg == thlk_pkg::S_CLEAR ? '0 : {cqb_next, cqh_next, cqt_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= thlk_pkg::S_CLEAR;
            init_reg  <= 1'b0;
            halt_reg  <= 1'b0;
            cur_reg   <= '0;
            op_reg    <= '0;
            l_reg     <= '0;
            c_reg     <= '0;
            clr_reg   <= '0;
            t_reg     <= '0;
            done_reg  <= 1'b0;
            st_reg    <= '0;
            nt_reg    <= '0;
            rqh_reg   <= '0;
            rqt_reg   <= '0;
            rqb_reg   <= 1'b0;
            cqh_reg   <= '0;
            cqt_reg   <= '0;
            cqb_reg   <= 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                ts_reg[i] <= thlk_pkg::TS_FREE;
                rv_reg[i] <= 1'b0;
                rp_reg[i] <= '0;
            end
            for (int i = 0; i < LOCK_SLOTS; i++)
            begin
                ov_reg[i]  <= 1'b0;
                own_reg[i] <= '0;
                lqh_reg[i] <= '0;
                lqt_reg[i] <= '0;
                lqb_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            halt_reg  <= halt_next;
            cur_reg   <= cur_next;
            op_reg    <= op_next;
            l_reg     <= l_next;
            c_reg     <= c_next;
            clr_reg   <= clr_next;
            t_reg     <= t_next;
            done_reg  <= done_next;
            st_reg    <= st_next;
            nt_reg    <= nt_next;
            rqh_reg   <= rqh_next;
            rqt_reg   <= rqt_next;
            rqb_reg   <= rqb_next;
            cqh_reg   <= cqh_next;
            cqt_reg   <= cqt_next;
            cqb_reg   <= cqb_next;
            ts_reg    <= ts_next;
            rv_reg    <= rv_next;
            rp_reg    <= rp_next;
            ov_reg    <= ov_next;
            own_reg   <= own_next;
            lqh_reg   <= lqh_next;
            lqt_reg   <= lqt_next;
            lqb_reg   <= lqb_next;
        end
    end

    always_comb
    begin
        cur_w          = 9'(cur_reg);
        nt_w           = 9'(nt_reg);
        busy           = state_reg != thlk_pkg::S_IDLE;
        done           = done_reg;
        status         = st_reg;
        running_thread = cur_w[3:0];
        new_thread     = nt_w[3:0];
        halted         = halt_reg;
    end

    `THLK_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt flag cleared")
    `THLK_ASSERT_NOW(a_done_idle, done_reg, state_reg == thlk_pkg::S_IDLE, "result while busy")
    `THLK_ASSERT_NOW(a_halt_status, done_reg && st_reg == thlk_pkg::ST_HALTED, halt_reg, "halted status without halt")
    `THLK_ASSERT_NOW(a_clear_quiet, state_reg == thlk_pkg::S_CLEAR, !done_reg && !init_reg, "activity during clear")
endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for thread_lock_condvar_scheduler_top: thread, lock and condvar requests.
// Depends on thlk_pkg and the RTL; a built-in scheduler model predicts each result.
`timescale 1ns / 100ps
module testbench;
    localparam int RDYQ = 0;
    localparam int LQ0 = 1;
    localparam int CQ0 = 17;
    localparam int NQ = 273;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_REQS = 1800;

    typedef struct {
        logic [3:0] head;
        logic [3:0] tail;
        bit         busy;
    } tq_t;

    typedef struct {
        bit         init_done;
        bit         halt;
        logic [3:0] cur;
        logic [2:0] tstat [16];
        logic [3:0] nxt [16];
        bit         rl_v [16];
        logic [3:0] rl_lock [16];
        bit         own_v [16];
        logic [3:0] owner [16];
        tq_t        q [NQ];
    } sched_t;

    typedef struct {
        logic [2:0] st;
        logic [3:0] run;
        logic [3:0] nt;
        logic       hlt;
    } sched_res_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [3:0] op;
    logic [3:0] lock_id;
    logic [3:0] cond_id;
    logic       done;
    logic [2:0] status;
    logic [3:0] running_thread;
    logic [3:0] new_thread;
    logic       halted;

    sched_t     model;
    sched_res_t sched_q[$];
    int         fails;
    int         sent;
    int         checked;
    int         no_free_seen;
    int         own_err_seen;
    int         stall_cnt;
    bit         no_gap;

    thread_lock_condvar_scheduler_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .lock_id(lock_id), .cond_id(cond_id), .done(done), .status(status),
        .running_thread(running_thread), .new_thread(new_thread), .halted(halted)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void q_put(inout sched_t s, input int qi, input int t);
        if (s.q[qi].busy)
            s.nxt[s.q[qi].tail] = 4'(t);
        else
        begin
            s.q[qi].head = 4'(t);
            s.q[qi].busy = 1'b1;
        end
        s.q[qi].tail = 4'(t);
    endfunction

    function automatic int q_take(inout sched_t s, input int qi);
        int h;
        h = s.q[qi].head;
        if (s.q[qi].head == s.q[qi].tail)
            s.q[qi].busy = 1'b0;
        else
            s.q[qi].head = s.nxt[h];
        return h;
    endfunction

    function automatic void make_ready(inout sched_t s, input int t);
        s.tstat[t] = thlk_pkg::TS_READY;
        q_put(s, RDYQ, t);
    endfunction

    function automatic void switch_thread(inout sched_t s);
        int t;
        int l;
        while (s.q[RDYQ].busy)
        begin
            t = q_take(s, RDYQ);
            if (s.rl_v[t])
            begin
                l = s.rl_lock[t];
                s.rl_v[t] = 1'b0;
                if (!s.own_v[l])
                begin
                    s.own_v[l] = 1'b1;
                    s.owner[l] = 4'(t);
                end
                else if (s.owner[l] != t)
                begin
                    s.tstat[t] = thlk_pkg::TS_LOCKWAIT;
                    q_put(s, LQ0 + l, t);
                    continue;
                end
            end
            s.cur = 4'(t);
            s.tstat[t] = thlk_pkg::TS_RUN;
            return;
        end
        s.halt = 1'b1;
    endfunction

    function automatic void release_lock(inout sched_t s, input int l);
        int w;
        s.own_v[l] = 1'b0;
        if (s.q[LQ0 + l].busy)
        begin
            w = q_take(s, LQ0 + l);
            s.own_v[l] = 1'b1;
            s.owner[l] = 4'(w);
            make_ready(s, w);
        end
    endfunction

    function automatic sched_res_t sched_step(inout sched_t s, input logic [3:0] o,
                                              input logic [3:0] lk, input logic [3:0] cd);
        sched_res_t r;
        int         cur;
        int         i;
        int         l;
        int         c;
        bit         owned;
        r.st = thlk_pkg::ST_OK;
        r.nt = 4'd0;
        l = lk;
        c = l * 16 + cd;
        cur = s.cur;
        owned = s.own_v[l] && s.owner[l] == s.cur;
        if (s.halt)
            r.st = thlk_pkg::ST_HALTED;
        else if (o == thlk_pkg::OP_INIT)
        begin
            if (s.init_done)
                r.st = thlk_pkg::ST_INIT_ERR;
            else
            begin
                s.init_done = 1'b1;
                s.cur = 4'd0;
                s.tstat[0] = thlk_pkg::TS_RUN;
            end
        end
        else if (o > thlk_pkg::OP_FINISH)
            r.st = thlk_pkg::ST_OK;
        else if (!s.init_done)
            r.st = thlk_pkg::ST_INIT_ERR;
        else
        begin
            case (o)
                thlk_pkg::OP_CREATE:
                begin
                    for (i = 0; i < 16; i++)
                        if (s.tstat[i] == thlk_pkg::TS_FREE)
                            break;
                    if (i == 16)
                        r.st = thlk_pkg::ST_NO_FREE;
                    else
                    begin
                        s.rl_v[i] = 1'b0;
                        make_ready(s, i);
                        r.nt = 4'(i);
                    end
                end
                thlk_pkg::OP_YIELD:
                begin
                    make_ready(s, cur);
                    switch_thread(s);
                end
                thlk_pkg::OP_LOCK:
                begin
                    if (owned)
                        r.st = thlk_pkg::ST_NOT_OWN;
                    else if (!s.own_v[l])
                    begin
                        s.own_v[l] = 1'b1;
                        s.owner[l] = 4'(cur);
                    end
                    else
                    begin
                        s.tstat[cur] = thlk_pkg::TS_LOCKWAIT;
                        q_put(s, LQ0 + l, cur);
                        switch_thread(s);
                    end
                end
                thlk_pkg::OP_UNLOCK:
                begin
                    if (!owned)
                        r.st = thlk_pkg::ST_NOT_OWN;
                    else
                        release_lock(s, l);
                end
                thlk_pkg::OP_WAIT:
                begin
                    if (!owned)
                        r.st = thlk_pkg::ST_NOT_OWN;
                    else
                    begin
                        s.tstat[cur] = thlk_pkg::TS_CONDWAIT;
                        s.rl_v[cur] = 1'b1;
                        s.rl_lock[cur] = 4'(l);
                        q_put(s, CQ0 + c, cur);
                        release_lock(s, l);
                        switch_thread(s);
                    end
                end
                thlk_pkg::OP_SIGNAL:
                begin
                    if (s.q[CQ0 + c].busy)
                        make_ready(s, q_take(s, CQ0 + c));
                end
                thlk_pkg::OP_BROADCAST:
                begin
                    while (s.q[CQ0 + c].busy)
                        make_ready(s, q_take(s, CQ0 + c));
                end
                default:
                begin
                    s.tstat[cur] = thlk_pkg::TS_FREE;
                    s.rl_v[cur] = 1'b0;
                    switch_thread(s);
                end
            endcase
        end
        r.run = s.cur;
        r.hlt = s.halt;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one request, held until accepted; the model advances at acceptance
    task automatic send_req(input logic [3:0] o, input logic [3:0] l, input logic [3:0] c);
        int g;
        op <= o;
        lock_id <= l;
        cond_id <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sched_q.insert(sched_q.size(), sched_step(model, o, l, c));
        sent++;
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sched_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        sched_res_t e;
        if (done)
        begin
            if (sched_q.size() == 0)
            begin
                $error("result with no request outstanding");
                fails++;
            end
            else
            begin
                e = sched_q[0];
                sched_q.delete(0);
                checked++;
                if (e.st == thlk_pkg::ST_NO_FREE)
                    no_free_seen++;
                if (e.st == thlk_pkg::ST_NOT_OWN)
                    own_err_seen++;
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    fails++;
                end
                if (running_thread !== e.run)
                begin
                    $error("running_thread: expected %0d, got %0d", e.run, running_thread);
                    fails++;
                end
                if (new_thread !== e.nt)
                begin
                    $error("new_thread: expected %0d, got %0d", e.nt, new_thread);
                    fails++;
                end
                if (halted !== e.hlt)
                begin
                    $error("halted: expected %0d, got %0d", e.hlt, halted);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int held_lock();
        for (int i = 0; i < 16; i++)
            if (model.own_v[i] && model.owner[i] == model.cur)
                return i;
        return -1;
    endfunction

    task automatic test_before_init();
        send_req(thlk_pkg::OP_YIELD, 4'd0, 4'd0);
        send_req(4'd15, 4'd15, 4'd15);
        send_req(thlk_pkg::OP_LOCK, 4'd1, 4'd0);
    endtask

    task automatic test_init();
        send_req(thlk_pkg::OP_INIT, 4'd0, 4'd0);
        send_req(thlk_pkg::OP_INIT, 4'd0, 4'd0);
    endtask

    task automatic test_create_full();
        for (int i = 0; i < 16; i++)
            send_req(thlk_pkg::OP_CREATE, 4'd0, 4'd0);
    endtask

    task automatic test_lock_cond();
        send_req(thlk_pkg::OP_LOCK, 4'd15, 4'd0);
        send_req(thlk_pkg::OP_LOCK, 4'd15, 4'd0);
        send_req(thlk_pkg::OP_UNLOCK, 4'd5, 4'd0);
        send_req(thlk_pkg::OP_WAIT, 4'd5, 4'd9);
        send_req(thlk_pkg::OP_WAIT, 4'd15, 4'd15);
        send_req(thlk_pkg::OP_SIGNAL, 4'd15, 4'd15);
        send_req(thlk_pkg::OP_BROADCAST, 4'd0, 4'd0);
    endtask

    task automatic test_random();
        int         n;
        int         w;
        int         hl;
        int         tries;
        logic [3:0] o;
        logic [3:0] l;
        logic [3:0] c;
        sched_t     trial;
        sched_res_t r;
        n = 0;
        while (n < RANDOM_REQS)
        begin
            if (n % 150 == 0)
                no_gap = ($urandom_range(0, 3) == 0);
            if (n == 900)
                drain();
            tries = 0;
            do
            begin
                w = $urandom_range(0, 99);
                l = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
                c = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
                hl = held_lock();
                if (w < 8)
                    o = thlk_pkg::OP_CREATE;
                else if (w < 20)
                    o = thlk_pkg::OP_YIELD;
                else if (w < 40)
                    o = thlk_pkg::OP_LOCK;
                else if (w < 58)
                    o = thlk_pkg::OP_UNLOCK;
                else if (w < 70)
                    o = thlk_pkg::OP_WAIT;
                else if (w < 82)
                    o = thlk_pkg::OP_SIGNAL;
                else if (w < 88)
                    o = thlk_pkg::OP_BROADCAST;
                else if (w < 96)
                    o = thlk_pkg::OP_FINISH;
                else if (w < 97)
                    o = thlk_pkg::OP_INIT;
                else
                    o = 4'($urandom_range(9, 15));
                if ((o == thlk_pkg::OP_UNLOCK || o == thlk_pkg::OP_WAIT) && hl >= 0 &&
                    $urandom_range(0, 4) != 0)
                    l = 4'(hl);
                trial = model;
                r = sched_step(trial, o, l, c);
                tries++;
            end
            while (tries < 20 && (trial.halt ||
                   (o == thlk_pkg::OP_FINISH && hl >= 0 && $urandom_range(0, 9) != 0)));
            if (trial.halt)
            begin
                o = thlk_pkg::OP_YIELD;
                l = 4'd0;
                c = 4'd0;
            end
            send_req(o, l, c);
            if (o <= thlk_pkg::OP_FINISH)
                n++;
        end
        no_gap = 1'b0;
    endtask

    task automatic test_halt();
        int k;
        k = 0;
        while (!model.halt && k < 60)
        begin
            send_req(thlk_pkg::OP_FINISH, 4'd0, 4'd0);
            k++;
        end
        send_req(thlk_pkg::OP_YIELD, 4'd0, 4'd0);
        send_req(thlk_pkg::OP_LOCK, 4'd15, 4'd15);
    endtask

    initial
    begin
        fails = 0;
        sent = 0;
        checked = 0;
        no_free_seen = 0;
        own_err_seen = 0;
        stall_cnt = 0;
        no_gap = 1'b0;
        model = '{default: '0};
        for (int i = 0; i < NQ; i++)
            model.q[i] = '{4'd0, 4'd0, 1'b0};
        for (int i = 0; i < 16; i++)
        begin
            model.tstat[i] = thlk_pkg::TS_FREE;
            model.nxt[i] = 4'd0;
            model.rl_v[i] = 1'b0;
            model.rl_lock[i] = 4'd0;
            model.own_v[i] = 1'b0;
            model.owner[i] = 4'd0;
        end
        rst_n <= 1'b0;
        start <= 1'b0;
        op <= 4'd0;
        lock_id <= 4'd0;
        cond_id <= 4'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_init();
        test_create_full();
        test_lock_cond();
        drain();
        test_random();
        test_halt();
        drain();
        $display("%0d requests sent, %0d results checked", sent, checked);
        $display("%0d no-free-thread and %0d ownership errors seen, run ended halted",
                 no_free_seen, own_err_seen);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
